// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types, region codes and the divide-by-255 helper for the HSV to RGB converter.
// No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam logic [7:0] FULL_SCALE  = 8'd255;
  localparam logic [7:0] REGION_SPAN = 8'd43;

  // Hue regions, six slices of the color circle
  localparam logic [2:0] REGION_0 = 3'd0;
  localparam logic [2:0] REGION_1 = 3'd1;
  localparam logic [2:0] REGION_2 = 3'd2;
  localparam logic [2:0] REGION_3 = 3'd3;
  localparam logic [2:0] REGION_4 = 3'd4;
  localparam logic [2:0] REGION_5 = 3'd5;

  // Output of the hue split stage
  typedef struct packed {
    logic [2:0] region;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
    logic       grey;
  } split_t;

  // Output of the level pipeline
  typedef struct packed {
    logic [2:0] region;
    logic [7:0] val;
    logic       grey;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } levels_t;

  // floor(x / 255), exact for x up to 255 * 255 (all products of two 8-bit levels)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ===== rtl/hsv2rgb_split.sv =====
// First pipeline stage: hue region and scaled in-region position.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           hue,
  input  logic [7:0]           saturation,
  input  logic [7:0]           brightness,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsv2rgb_pkg::split_t  out_word
);

  logic [2:0] region_next;
  logic [7:0] base;
  logic [5:0] offset;
  logic [7:0] frac_next;
  logic       valid;
  hsv2rgb_pkg::split_t word;

  always_comb begin
    if (hue >= 8'd215) begin
      region_next = hsv2rgb_pkg::REGION_5;
    end else if (hue >= 8'd172) begin
      region_next = hsv2rgb_pkg::REGION_4;
    end else if (hue >= 8'd129) begin
      region_next = hsv2rgb_pkg::REGION_3;
    end else if (hue >= 8'd86) begin
      region_next = hsv2rgb_pkg::REGION_2;
    end else if (hue >= hsv2rgb_pkg::REGION_SPAN) begin
      region_next = hsv2rgb_pkg::REGION_1;
    end else begin
      region_next = hsv2rgb_pkg::REGION_0;
    end
  end

  always_comb begin
    case (region_next)
      hsv2rgb_pkg::REGION_1: base = 8'd43;
      hsv2rgb_pkg::REGION_2: base = 8'd86;
      hsv2rgb_pkg::REGION_3: base = 8'd129;
      hsv2rgb_pkg::REGION_4: base = 8'd172;
      hsv2rgb_pkg::REGION_5: base = 8'd215;
      default:               base = 8'd0;
    endcase
  end

  // offset < 43, times 6 stays below 256
  assign offset    = 6'(hue - base);
  assign frac_next = {offset, 2'b00} + {1'b0, offset, 1'b0};

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word.region <= region_next;
      word.frac   <= frac_next;
      word.sat    <= saturation;
      word.val    <= brightness;
      word.grey   <= (saturation == 8'd0);
    end
  end

  a_split_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (word.frac <= 8'd252 && word.region <= hsv2rgb_pkg::REGION_5))
    else $error("split stage produced out-of-range region or fraction");

endmodule

// ===== rtl/hsv2rgb_levels.sv =====
// Four-stage pipeline forming the p, q and t levels from saturation, fraction and value.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_levels (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv2rgb_pkg::split_t   in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv2rgb_pkg::levels_t  out_word
);

  logic [3:0] valid;
  logic [3:0] ready;

  // stage A: saturation products
  logic [2:0]  a_region;
  logic [7:0]  a_val;
  logic [7:0]  a_sat;
  logic        a_grey;
  logic [15:0] a_sf;
  logic [15:0] a_sg;
  // stage B: complemented scale factors
  logic [2:0]  b_region;
  logic [7:0]  b_val;
  logic        b_grey;
  logic [7:0]  b_fq;
  logic [7:0]  b_ft;
  logic [7:0]  b_fp;
  // stage C: value products
  logic [2:0]  c_region;
  logic [7:0]  c_val;
  logic        c_grey;
  logic [15:0] c_vq;
  logic [15:0] c_vt;
  logic [15:0] c_vp;
  // stage D: levels
  hsv2rgb_pkg::levels_t d_word;

  assign ready[3] = !valid[3] || out_ready;
  assign ready[2] = !valid[2] || ready[3];
  assign ready[1] = !valid[1] || ready[2];
  assign ready[0] = !valid[0] || ready[1];

  assign in_ready  = ready[0];
  assign out_valid = valid[3];
  assign out_word  = d_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 4'b0;
    end else begin
      if (ready[0]) valid[0] <= in_valid;
      if (ready[1]) valid[1] <= valid[0];
      if (ready[2]) valid[2] <= valid[1];
      if (ready[3]) valid[3] <= valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      a_region <= in_word.region;
      a_val    <= in_word.val;
      a_sat    <= in_word.sat;
      a_grey   <= in_word.grey;
      a_sf     <= 16'(in_word.sat) * 16'(in_word.frac);
      a_sg     <= 16'(in_word.sat) * 16'(hsv2rgb_pkg::FULL_SCALE - in_word.frac);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1] && valid[0]) begin
      b_region <= a_region;
      b_val    <= a_val;
      b_grey   <= a_grey;
      b_fq     <= hsv2rgb_pkg::FULL_SCALE - hsv2rgb_pkg::div255(a_sf);
      b_ft     <= hsv2rgb_pkg::FULL_SCALE - hsv2rgb_pkg::div255(a_sg);
      b_fp     <= hsv2rgb_pkg::FULL_SCALE - a_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[2] && valid[1]) begin
      c_region <= b_region;
      c_val    <= b_val;
      c_grey   <= b_grey;
      c_vq     <= 16'(b_val) * 16'(b_fq);
      c_vt     <= 16'(b_val) * 16'(b_ft);
      c_vp     <= 16'(b_val) * 16'(b_fp);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[3] && valid[2]) begin
      d_word.region <= c_region;
      d_word.val    <= c_val;
      d_word.grey   <= c_grey;
      d_word.q      <= hsv2rgb_pkg::div255(c_vq);
      d_word.t      <= hsv2rgb_pkg::div255(c_vt);
      d_word.p      <= hsv2rgb_pkg::div255(c_vp);
    end
  end

  // p is the floor, q and t sit between p and the value
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    valid[3] |-> (d_word.p <= d_word.q && d_word.p <= d_word.t &&
                  d_word.q <= d_word.val && d_word.t <= d_word.val))
    else $error("level ordering p <= q,t <= value violated");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    valid[3] && !out_ready |=> valid[3] && $stable(d_word))
    else $error("level stage lost or changed a stalled word");

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, 8-bit integer six-region method.
// Throughput one word per clock while the receiver does not stall the output.
// Six register stages: hue split, saturation multiply, scale, value multiply, divide, place.
// Each stage has its own valid bit and may fill while later stages stall.
// Reset (rst, synchronous) clears all valid bits; the datapath registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_split, hsv2rgb_levels.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  hsv2rgb_pkg::split_t  split_word;
  hsv2rgb_pkg::levels_t lvl_word;
  logic                 split_valid;
  logic                 split_ready;
  logic                 lvl_valid;
  logic                 lvl_ready;

  logic                 valid;
  logic [7:0]           red_next;
  logic [7:0]           green_next;
  logic [7:0]           blue_next;

  // Stage 1: region and fraction of the hue
  hsv2rgb_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (split_valid),
    .out_ready  (split_ready),
    .out_word   (split_word)
  );

  // Stages 2-5: p, q, t through two multiply / divide-by-255 pairs
  hsv2rgb_levels u_levels (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_word   (split_word),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_word  (lvl_word)
  );

  // Stage 6: place value and levels on the channels by region.
  // Zero saturation forces grey at the value.
  always_comb begin
    if (lvl_word.grey) begin
      red_next   = lvl_word.val;
      green_next = lvl_word.val;
      blue_next  = lvl_word.val;
    end else begin
      case (lvl_word.region)
        hsv2rgb_pkg::REGION_0: begin
          red_next = lvl_word.val; green_next = lvl_word.t;   blue_next = lvl_word.p;
        end
        hsv2rgb_pkg::REGION_1: begin
          red_next = lvl_word.q;   green_next = lvl_word.val; blue_next = lvl_word.p;
        end
        hsv2rgb_pkg::REGION_2: begin
          red_next = lvl_word.p;   green_next = lvl_word.val; blue_next = lvl_word.t;
        end
        hsv2rgb_pkg::REGION_3: begin
          red_next = lvl_word.p;   green_next = lvl_word.q;   blue_next = lvl_word.val;
        end
        hsv2rgb_pkg::REGION_4: begin
          red_next = lvl_word.t;   green_next = lvl_word.p;   blue_next = lvl_word.val;
        end
        default: begin
          red_next = lvl_word.val; green_next = lvl_word.p;   blue_next = lvl_word.q;
        end
      endcase
    end
  end

  // Output register: takes a new word whenever it is empty or being drained
  assign lvl_ready = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (lvl_ready) begin
      valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready && lvl_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // Input can only be blocked when the output holds an untaken word
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> valid)
    else $error("input stalled with empty output register");

  // One channel always carries the value, the largest level
  a_peak_channel: assert property (@(posedge clk) disable iff (rst)
    lvl_ready && lvl_valid |=>
      (red == $past(lvl_word.val) || green == $past(lvl_word.val) ||
       blue == $past(lvl_word.val)))
    else $error("no channel carries the value level");

  // On release of reset the output register is empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !valid)
    else $error("output valid after reset");

endmodule

// ===== verif/hsv_color_checker.sv =====
// Checker for the HSV to RGB converter: watches both channels, predicts each color
// from the accepted input word and compares it with the result word.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv_color_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output int         fail_count,
  output int         words_in_flight
);

  localparam int unsigned FRAC_STEPS = 6;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_word_t;

  color_word_t expected_colors[$];

  function automatic int unsigned scale_by_level(input int unsigned a, input int unsigned b);
    return (a * b) / hsv2rgb_pkg::FULL_SCALE;
  endfunction

  // Six-region integer conversion; zero saturation gives grey at the value
  function automatic color_word_t predict_color(input logic [7:0] h, input logic [7:0] s,
                                                input logic [7:0] v);
    color_word_t c;
    logic [2:0]  region;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    c.hue = h;
    c.sat = s;
    c.val = v;
    if (s == 8'd0) begin
      c.red   = v;
      c.green = v;
      c.blue  = v;
    end else begin
      region = 3'(h / hsv2rgb_pkg::REGION_SPAN);
      frac = ((h - region * hsv2rgb_pkg::REGION_SPAN) * FRAC_STEPS) & 8'hFF;
      p = scale_by_level(v, hsv2rgb_pkg::FULL_SCALE - s);
      q = scale_by_level(v, hsv2rgb_pkg::FULL_SCALE - scale_by_level(s, frac));
      t = scale_by_level(v, hsv2rgb_pkg::FULL_SCALE -
                            scale_by_level(s, hsv2rgb_pkg::FULL_SCALE - frac));
      case (region)
        hsv2rgb_pkg::REGION_0: begin c.red = v;      c.green = t[7:0]; c.blue = p[7:0]; end
        hsv2rgb_pkg::REGION_1: begin c.red = q[7:0]; c.green = v;      c.blue = p[7:0]; end
        hsv2rgb_pkg::REGION_2: begin c.red = p[7:0]; c.green = v;      c.blue = t[7:0]; end
        hsv2rgb_pkg::REGION_3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v;      end
        hsv2rgb_pkg::REGION_4: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v;      end
        default:               begin c.red = v;      c.green = p[7:0]; c.blue = q[7:0]; end
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input color_word_t exp_word,
                                 input int wanted);
    $display("[%0t] mismatch %s: got %0d, want %0d (hue %0d sat %0d val %0d)", $realtime,
             what, got, wanted, exp_word.hue, exp_word.sat, exp_word.val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    color_word_t exp_word;
    if (rst) begin
      fail_count = 0;
      expected_colors.delete();
      words_in_flight <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_colors.push_back(predict_color(hue, saturation, brightness));
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("[%0t] unexpected result word: red %0d green %0d blue %0d", $realtime,
                   red, green, blue);
          fail_count++;
        end else begin
          exp_word = expected_colors.pop_front();
          if (red !== exp_word.red)
            report_mismatch("red", red, exp_word, exp_word.red);
          if (green !== exp_word.green)
            report_mismatch("green", green, exp_word, exp_word.green);
          if (blue !== exp_word.blue)
            report_mismatch("blue", blue, exp_word, exp_word.blue);
        end
      end
      words_in_flight <= expected_colors.size();
    end
  end

endmodule

// ===== verif/hsv_to_rgb_converter_tb.sv =====
// Top of the HSV to RGB converter testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on hsv_to_rgb_converter and hsv_color_checker.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

  localparam int RANDOM_PER_PHASE = 275;
  localparam int HOLD_OFF_CYCLES  = 40;    // well past the pipeline depth
  localparam int DRAIN_TAIL       = 20;    // well past the pipeline latency
  localparam int WATCHDOG_LIMIT   = 4000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] hue = 8'd0;
  logic [7:0] saturation = 8'd0;
  logic [7:0] brightness = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  int fail_count;
  int words_in_flight;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_offs_asked = 0;

  // region boundaries: first and last hue of each slice
  int hue_edges [12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};

  always #5 clk = ~clk;

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsv_color_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .hue             (hue),
    .saturation      (saturation),
    .brightness      (brightness),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight)
  );

  // Offer one word; valid stays up until the handshake, gaps only come before it
  task automatic send_word(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding color to come back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  // Level biased toward the extremes and near-extremes
  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      3:       return 8'($urandom_range(252, 254));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_word();
    logic [7:0] h;
    logic [7:0] s;
    if ($urandom_range(7) == 0)
      h = 8'(hue_edges[$urandom_range(11)]);
    else
      h = 8'($urandom_range(255));
    // roughly one word in five is grey
    s = ($urandom_range(9) == 0) ? 8'd0 : pick_level();
    send_word(h, s, pick_level());
  endtask

  // Receiver: random stalls, plus a long hold-off each time stimulus asks for one
  initial begin
    int hold_offs_taken;
    hold_offs_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_offs_taken < hold_offs_asked) begin
        hold_offs_taken++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without a word moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 1: sender idles now and then, receiver mostly stalled
    send_idle_pct = 28;
    recv_idle_pct = 73;

    // Directed: grey cases, corners, every region boundary at full levels, some at low levels
    send_word(8'd0, 8'd0, 8'd0);
    send_word(8'd255, 8'd255, 8'd255);
    send_word(8'd200, 8'd0, 8'd77);
    send_word(8'd0, 8'd0, 8'd255);
    send_word(8'd128, 8'd255, 8'd0);
    foreach (hue_edges[i])
      send_word(8'(hue_edges[i]), 8'd255, 8'd255);
    send_word(8'd42, 8'd1, 8'd255);
    send_word(8'd215, 8'd255, 8'd1);
    send_word(8'd100, 8'd128, 8'd200);
    send_word(8'd170, 8'd254, 8'd254);
    send_word(8'd85, 8'd170, 8'd85);
    send_word(8'd240, 8'd1, 8'd1);

    repeat (RANDOM_PER_PHASE) send_random_word();

    // Phase 2: the other way round, with one full drain halfway
    send_idle_pct = 73;
    recv_idle_pct = 28;
    repeat (RANDOM_PER_PHASE / 2) send_random_word();
    drain_pipeline();
    repeat (RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2) send_random_word();

    // Phase 3: no idling; an early long receiver hold-off backs the pipeline up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (20) send_random_word();
    hold_offs_asked <= hold_offs_asked + 1;
    repeat (RANDOM_PER_PHASE - 20) send_random_word();

    drain_pipeline();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_split.sv
rtl/hsv2rgb_levels.sv
rtl/hsv_to_rgb_converter.sv
verif/hsv_color_checker.sv
verif/hsv_to_rgb_converter_tb.sv
